// ===== rtl/tei_pkg.sv =====
// ----------------------------------------------------------------------------
// tei_pkg
// Shared widths, types and constants for the triangle edge crossing block.
// ----------------------------------------------------------------------------
package tei_pkg;

	localparam int COORD_W = 16;
	localparam int NVERT   = 3;
	localparam int NPAIR   = NVERT * NVERT;
	localparam int EDGE_W  = 2;

	// Edge direction and offset vectors, their products and cross products.
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;

	// Split of a cross product for the point multiply.
	localparam int LO_W    = (CROSS_W + 1) / 2;
	localparam int HI_W    = CROSS_W - LO_W;
	localparam int PPL_W   = DIFF_W + LO_W + 1;
	localparam int PPH_W   = DIFF_W + HI_W + 1;
	localparam int SL_W    = PPL_W + 1;
	localparam int SH_W    = PPH_W + 1;
	localparam int NUM_W   = SH_W + LO_W;
	localparam int MAG_W   = NUM_W - 1;
	localparam int Q_W     = COORD_W + 1;

	// Queue between front and back.
	localparam int QPTR_W  = 2;
	localparam int QDEPTH  = 2 ** QPTR_W;

	// Vertex that ends edge i.
	localparam int NEXT_V [NVERT] = '{1, 2, 0};

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [CROSS_W-1:0] cross_t;
	typedef logic [EDGE_W-1:0]         edge_t;

	// One classified pair: the winning edge pair and what the back needs.
	typedef struct packed {
		logic   hit;
		edge_t  edge_a;
		edge_t  edge_b;
		coord_t px;
		coord_t py;
		diff_t  dx;
		diff_t  dy;
		cross_t den;
		cross_t tn;
	} qitem_t;

endpackage

// ===== rtl/tei_in_if.sv =====
// ----------------------------------------------------------------------------
// tei_in_if
// Valid/ready channel carrying one pair of triangles.
// ----------------------------------------------------------------------------
interface tei_in_if;
	import tei_pkg::*;

	logic   valid;
	logic   ready;
	coord_t a_x0;
	coord_t a_y0;
	coord_t a_x1;
	coord_t a_y1;
	coord_t a_x2;
	coord_t a_y2;
	coord_t b_x0;
	coord_t b_y0;
	coord_t b_x1;
	coord_t b_y1;
	coord_t b_x2;
	coord_t b_y2;

	modport source (
		output valid, a_x0, a_y0, a_x1, a_y1, a_x2, a_y2,
		output b_x0, b_y0, b_x1, b_y1, b_x2, b_y2,
		input  ready
	);
	modport sink (
		input  valid, a_x0, a_y0, a_x1, a_y1, a_x2, a_y2,
		input  b_x0, b_y0, b_x1, b_y1, b_x2, b_y2,
		output ready
	);
endinterface

// ===== rtl/tei_out_if.sv =====
// ----------------------------------------------------------------------------
// tei_out_if
// Valid/ready channel carrying one crossing result.
// ----------------------------------------------------------------------------
interface tei_out_if;
	import tei_pkg::*;

	logic   valid;
	logic   ready;
	logic   hit;
	coord_t cross_x;
	coord_t cross_y;
	edge_t  edge_a;
	edge_t  edge_b;

	modport source (
		output valid, hit, cross_x, cross_y, edge_a, edge_b,
		input  ready
	);
	modport sink (
		input  valid, hit, cross_x, cross_y, edge_a, edge_b,
		output ready
	);
endinterface

// ===== rtl/tei_front.sv =====
// ----------------------------------------------------------------------------
// tei_front
// Four-stage classifier: edge vectors, products, cross products, segment
// tests for each A edge with each B edge, then pick the first crossing pair.
// ----------------------------------------------------------------------------
module tei_front (
	input  logic            clk,
	input  logic            arst_n,
	tei_in_if.sink          pair,
	output tei_pkg::qitem_t item,
	output logic            item_valid,
	input  logic            item_ready
);
	import tei_pkg::*;

	function automatic logic seg_hit(cross_t den, cross_t tn, cross_t un);
		logic pos;
		logic neg;
		pos = (den > 0) && (tn >= 0) && (tn <= den) && (un >= 0) && (un <= den);
		neg = (den < 0) && (tn <= 0) && (tn >= den) && (un <= 0) && (un >= den);
		return pos || neg;
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	logic found;

	coord_t ax [NVERT];
	coord_t ay [NVERT];
	coord_t bx [NVERT];
	coord_t by [NVERT];

	coord_t ax_s1 [NVERT], ay_s1 [NVERT];
	diff_t  dax_s1 [NVERT], day_s1 [NVERT], dbx_s1 [NVERT], dby_s1 [NVERT];
	diff_t  wx_s1 [NPAIR], wy_s1 [NPAIR];

	coord_t ax_s2 [NVERT], ay_s2 [NVERT];
	diff_t  dax_s2 [NVERT], day_s2 [NVERT];
	prod_t  d0_s2 [NPAIR], d1_s2 [NPAIR];
	prod_t  t0_s2 [NPAIR], t1_s2 [NPAIR];
	prod_t  u0_s2 [NPAIR], u1_s2 [NPAIR];

	coord_t ax_s3 [NVERT], ay_s3 [NVERT];
	diff_t  dax_s3 [NVERT], day_s3 [NVERT];
	cross_t den_s3 [NPAIR], tn_s3 [NPAIR], un_s3 [NPAIR];

	coord_t ax_s4 [NVERT], ay_s4 [NVERT];
	diff_t  dax_s4 [NVERT], day_s4 [NVERT];
	cross_t den_s4 [NPAIR], tn_s4 [NPAIR];
	logic   [NPAIR-1:0] hit_s4;

	assign ax[0] = pair.a_x0;
	assign ay[0] = pair.a_y0;
	assign ax[1] = pair.a_x1;
	assign ay[1] = pair.a_y1;
	assign ax[2] = pair.a_x2;
	assign ay[2] = pair.a_y2;
	assign bx[0] = pair.b_x0;
	assign by[0] = pair.b_y0;
	assign bx[1] = pair.b_x1;
	assign by[1] = pair.b_y1;
	assign bx[2] = pair.b_x2;
	assign by[2] = pair.b_y2;

	// Advance the whole front unless the last stage is blocked by the queue.
	assign en         = !v_s4 || item_ready;
	assign pair.ready = en;
	assign item_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= pair.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NVERT; i++) begin
				ax_s1[i]  <= ax[i];
				ay_s1[i]  <= ay[i];
				dax_s1[i] <= diff_t'(ax[NEXT_V[i]]) - diff_t'(ax[i]);
				day_s1[i] <= diff_t'(ay[NEXT_V[i]]) - diff_t'(ay[i]);
				dbx_s1[i] <= diff_t'(bx[NEXT_V[i]]) - diff_t'(bx[i]);
				dby_s1[i] <= diff_t'(by[NEXT_V[i]]) - diff_t'(by[i]);

				ax_s2[i]  <= ax_s1[i];
				ay_s2[i]  <= ay_s1[i];
				dax_s2[i] <= dax_s1[i];
				day_s2[i] <= day_s1[i];

				ax_s3[i]  <= ax_s2[i];
				ay_s3[i]  <= ay_s2[i];
				dax_s3[i] <= dax_s2[i];
				day_s3[i] <= day_s2[i];

				ax_s4[i]  <= ax_s3[i];
				ay_s4[i]  <= ay_s3[i];
				dax_s4[i] <= dax_s3[i];
				day_s4[i] <= day_s3[i];
			end
			for (int eb = 0; eb < NVERT; eb++) begin
				for (int ea = 0; ea < NVERT; ea++) begin
					wx_s1[eb*NVERT+ea] <= diff_t'(bx[eb]) - diff_t'(ax[ea]);
					wy_s1[eb*NVERT+ea] <= diff_t'(by[eb]) - diff_t'(ay[ea]);

					d0_s2[eb*NVERT+ea] <= dax_s1[ea] * dby_s1[eb];
					d1_s2[eb*NVERT+ea] <= day_s1[ea] * dbx_s1[eb];
					t0_s2[eb*NVERT+ea] <= wx_s1[eb*NVERT+ea] * dby_s1[eb];
					t1_s2[eb*NVERT+ea] <= wy_s1[eb*NVERT+ea] * dbx_s1[eb];
					u0_s2[eb*NVERT+ea] <= wx_s1[eb*NVERT+ea] * day_s1[ea];
					u1_s2[eb*NVERT+ea] <= wy_s1[eb*NVERT+ea] * dax_s1[ea];
				end
			end
			for (int k = 0; k < NPAIR; k++) begin
				den_s3[k] <= cross_t'(d0_s2[k]) - cross_t'(d1_s2[k]);
				tn_s3[k]  <= cross_t'(t0_s2[k]) - cross_t'(t1_s2[k]);
				un_s3[k]  <= cross_t'(u0_s2[k]) - cross_t'(u1_s2[k]);

				hit_s4[k] <= seg_hit(den_s3[k], tn_s3[k], un_s3[k]);
				den_s4[k] <= den_s3[k];
				tn_s4[k]  <= tn_s3[k];
			end
		end
	end

	// First crossing in B-outer, A-inner order wins.
	always_comb begin
		item  = '0;
		found = 1'b0;
		for (int eb = 0; eb < NVERT; eb++) begin
			for (int ea = 0; ea < NVERT; ea++) begin
				if (!found && hit_s4[eb*NVERT+ea]) begin
					found       = 1'b1;
					item.hit    = 1'b1;
					item.edge_a = EDGE_W'(ea);
					item.edge_b = EDGE_W'(eb);
					item.px     = ax_s4[ea];
					item.py     = ay_s4[ea];
					item.dx     = dax_s4[ea];
					item.dy     = day_s4[ea];
					item.den    = den_s4[eb*NVERT+ea];
					item.tn     = tn_s4[eb*NVERT+ea];
				end
			end
		end
	end

endmodule

// ===== rtl/tei_queue.sv =====
// ----------------------------------------------------------------------------
// tei_queue
// Small FIFO that decouples the classifier from the point calculation.
// ----------------------------------------------------------------------------
module tei_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  tei_pkg::qitem_t push_item,
	input  logic            push_valid,
	output logic            push_ready,
	output tei_pkg::qitem_t pop_item,
	output logic            pop_valid,
	input  logic            pop_ready
);
	import tei_pkg::*;

	qitem_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic                push;
	logic                pop;

	assign push_ready = count_q != (QPTR_W+1)'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/tei_div.sv =====
// ----------------------------------------------------------------------------
// tei_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tei_div (
	input  logic                      clk,
	input  logic                      en,
	input  logic [tei_pkg::MAG_W-1:0]   mag,
	input  logic [tei_pkg::CROSS_W-1:0] den,
	output logic [tei_pkg::Q_W-1:0]     quo
);
	import tei_pkg::*;

	logic [MAG_W-1:0]   rem_s [Q_W];
	logic [CROSS_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]     quo_s [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_stage
		logic [MAG_W-1:0]   rem_in;
		logic [MAG_W-1:0]   trial;
		logic [CROSS_W-1:0] den_in;
		logic [Q_W-1:0]     quo_in;
		logic               take;

		if (j == 0) begin : g_first
			assign rem_in = mag;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign den_in = den_s[j-1];
			assign quo_in = quo_s[j-1];
		end

		assign trial = MAG_W'(den_in) << (Q_W - 1 - j);
		assign take  = rem_in >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= take ? rem_in - trial : rem_in;
				den_s[j] <= den_in;
				quo_s[j] <= {quo_in[Q_W-2:0], take};
			end
		end
	end

	assign quo = quo_s[Q_W-1];

endmodule

// ===== rtl/tei_back.sv =====
// ----------------------------------------------------------------------------
// tei_back
// Crossing point: normalize sign, split multiply, add, take magnitude,
// divide both coordinates, restore sign and register the result.
// ----------------------------------------------------------------------------
module tei_back (
	input  logic            clk,
	input  logic            arst_n,
	input  tei_pkg::qitem_t item,
	input  logic            item_valid,
	output logic            item_ready,
	tei_out_if.source       result
);
	import tei_pkg::*;

	logic en;

	// Side band that rides along with the data.
	typedef struct packed {
		logic  hit;
		edge_t edge_a;
		edge_t edge_b;
	} side_t;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	side_t              sd_s1, sd_s2, sd_s3, sd_s4, sd_s5;

	coord_t             px_s1, py_s1;
	diff_t              dx_s1, dy_s1;
	logic [CROSS_W-1:0] den_s1, tn_s1;

	logic signed [PPL_W-1:0] pdl_x_s2, ptl_x_s2, pdl_y_s2, ptl_y_s2;
	logic signed [PPH_W-1:0] pdh_x_s2, pth_x_s2, pdh_y_s2, pth_y_s2;
	logic [CROSS_W-1:0]      den_s2, den_s3, den_s4, den_s5;

	logic signed [SL_W-1:0]  sl_x_s3, sl_y_s3;
	logic signed [SH_W-1:0]  sh_x_s3, sh_y_s3;

	logic signed [NUM_W-1:0] num_x_s4, num_y_s4;
	logic signed [NUM_W-1:0] abs_x, abs_y;

	logic [MAG_W-1:0]        mag_x_s5, mag_y_s5;
	logic                    neg_x_s5, neg_y_s5;

	logic                    v_sd  [Q_W];
	side_t                   sd_sd [Q_W];
	logic                    nx_sd [Q_W];
	logic                    ny_sd [Q_W];

	logic [Q_W-1:0]          quo_x, quo_y, sq_x, sq_y;

	logic                    out_valid_q;
	side_t                   out_side_q;
	coord_t                  out_x_q, out_y_q;

	assign en         = !out_valid_q || result.ready;
	assign item_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < Q_W; j++) begin
				v_sd[j] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_sd[0] <= v_s5;
			for (int j = 1; j < Q_W; j++) begin
				v_sd[j] <= v_sd[j-1];
			end
			out_valid_q <= v_sd[Q_W-1];
		end
	end

	always_comb begin
		abs_x = num_x_s4[NUM_W-1] ? -num_x_s4 : num_x_s4;
		abs_y = num_y_s4[NUM_W-1] ? -num_y_s4 : num_y_s4;
		sq_x  = nx_sd[Q_W-1] ? -quo_x : quo_x;
		sq_y  = ny_sd[Q_W-1] ? -quo_y : quo_y;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Flip signs so the denominator is positive.
			sd_s1  <= '{hit: item.hit, edge_a: item.edge_a, edge_b: item.edge_b};
			px_s1  <= item.px;
			py_s1  <= item.py;
			dx_s1  <= item.dx;
			dy_s1  <= item.dy;
			den_s1 <= item.den[CROSS_W-1] ? -item.den : item.den;
			tn_s1  <= item.den[CROSS_W-1] ? -item.tn : item.tn;

			// Partial products of P*den and d*tn.
			sd_s2    <= sd_s1;
			den_s2   <= den_s1;
			pdl_x_s2 <= px_s1 * $signed({1'b0, den_s1[LO_W-1:0]});
			pdh_x_s2 <= px_s1 * $signed({1'b0, den_s1[CROSS_W-1:LO_W]});
			ptl_x_s2 <= dx_s1 * $signed({1'b0, tn_s1[LO_W-1:0]});
			pth_x_s2 <= dx_s1 * $signed({1'b0, tn_s1[CROSS_W-1:LO_W]});
			pdl_y_s2 <= py_s1 * $signed({1'b0, den_s1[LO_W-1:0]});
			pdh_y_s2 <= py_s1 * $signed({1'b0, den_s1[CROSS_W-1:LO_W]});
			ptl_y_s2 <= dy_s1 * $signed({1'b0, tn_s1[LO_W-1:0]});
			pth_y_s2 <= dy_s1 * $signed({1'b0, tn_s1[CROSS_W-1:LO_W]});

			sd_s3   <= sd_s2;
			den_s3  <= den_s2;
			sl_x_s3 <= SL_W'(pdl_x_s2) + SL_W'(ptl_x_s2);
			sh_x_s3 <= SH_W'(pdh_x_s2) + SH_W'(pth_x_s2);
			sl_y_s3 <= SL_W'(pdl_y_s2) + SL_W'(ptl_y_s2);
			sh_y_s3 <= SH_W'(pdh_y_s2) + SH_W'(pth_y_s2);

			sd_s4    <= sd_s3;
			den_s4   <= den_s3;
			num_x_s4 <= (NUM_W'(sh_x_s3) <<< LO_W) + NUM_W'(sl_x_s3);
			num_y_s4 <= (NUM_W'(sh_y_s3) <<< LO_W) + NUM_W'(sl_y_s3);

			sd_s5    <= sd_s4;
			den_s5   <= den_s4;
			neg_x_s5 <= num_x_s4[NUM_W-1];
			neg_y_s5 <= num_y_s4[NUM_W-1];
			mag_x_s5 <= abs_x[MAG_W-1:0];
			mag_y_s5 <= abs_y[MAG_W-1:0];

			sd_sd[0] <= sd_s5;
			nx_sd[0] <= neg_x_s5;
			ny_sd[0] <= neg_y_s5;
			for (int j = 1; j < Q_W; j++) begin
				sd_sd[j] <= sd_sd[j-1];
				nx_sd[j] <= nx_sd[j-1];
				ny_sd[j] <= ny_sd[j-1];
			end

			// Zero everything on a miss.
			if (sd_sd[Q_W-1].hit) begin
				out_side_q <= sd_sd[Q_W-1];
				out_x_q    <= sq_x[COORD_W-1:0];
				out_y_q    <= sq_y[COORD_W-1:0];
			end else begin
				out_side_q <= '0;
				out_x_q    <= '0;
				out_y_q    <= '0;
			end
		end
	end

	tei_div u_div_x (
		.clk (clk),
		.en  (en),
		.mag (mag_x_s5),
		.den (den_s5),
		.quo (quo_x)
	);

	tei_div u_div_y (
		.clk (clk),
		.en  (en),
		.mag (mag_y_s5),
		.den (den_s5),
		.quo (quo_y)
	);

	assign result.valid   = out_valid_q;
	assign result.hit     = out_side_q.hit;
	assign result.edge_a  = out_side_q.edge_a;
	assign result.edge_b  = out_side_q.edge_b;
	assign result.cross_x = out_x_q;
	assign result.cross_y = out_y_q;

endmodule

// ===== rtl/triangle_edge_intersection.sv =====
// ----------------------------------------------------------------------------
// triangle_edge_intersection
// Throughput: one pair per cycle while the sink does not stall, set by the
// fully pipelined front and the two 17-stage pipelined dividers in the back.
// Reset: arst_n clears pipeline valid flags, queue pointers and queue count only.
// ----------------------------------------------------------------------------
module triangle_edge_intersection (
	input  logic       clk,
	input  logic       arst_n,
	tei_in_if.sink     pair,
	tei_out_if.source  result
);
	import tei_pkg::*;

	// Front: four stages. Edge and offset vectors, the products of each edge
	// pair (d0, d1, t0, t1, u0, u1), its cross products (den, tn, un), then the
	// inclusive segment test. The first crossing pair (B outer, A inner) is picked
	// combinationally from the last stage and pushed into the queue.
	qitem_t f_item;
	logic   f_valid;
	logic   f_ready;

	// Back side of the queue.
	qitem_t b_item;
	logic   b_valid;
	logic   b_ready;

	tei_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair       (pair),
		.item       (f_item),
		.item_valid (f_valid),
		.item_ready (f_ready)
	);

	// Queue: lets the front keep taking pairs while the result side stalls, until it is full.
	tei_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (f_item),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_item   (b_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready)
	);

	// Back: P + d*tn/den computed as (P*den + d*tn)/den, truncated toward
	// zero through a magnitude divide and a final sign restore. The output
	// register holds the result until the sink takes the transfer.
	tei_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (b_item),
		.item_valid (b_valid),
		.item_ready (b_ready),
		.result     (result)
	);

	// Edge indices stay within the triangle.
	a_edge_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.edge_a <= EDGE_W'(NVERT - 1)) &&
		                 (result.edge_b <= EDGE_W'(NVERT - 1)))
		else $error("edge index out of range");

	// A miss carries an all-zero payload.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.hit) |-> (result.cross_x == '0) &&
		(result.cross_y == '0) && (result.edge_a == '0) && (result.edge_b == '0))
		else $error("miss with nonzero payload");

	// Front must hold a classified pair while the queue is full.
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && !f_ready) |=> (f_valid && $stable(f_item)))
		else $error("front dropped a blocked item");

endmodule

// ===== tb/sv/tei_tb_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tei_tb_scoreboard
// Crossing predictor and result checker for the triangle edge block.
// ----------------------------------------------------------------------------
class tei_crossing_board;
	typedef struct {
		logic         hit;
		logic [15:0]  cx;
		logic [15:0]  cy;
		logic [1:0]   ea;
		logic [1:0]   eb;
	} crossing_t;

	crossing_t pending[$];
	int        errors;

	function new();
		errors = 0;
	endfunction

	// Exact segment test on one edge pair; fills the truncated point on a hit.
	static function bit seg_hit(longint px, longint py, longint px2, longint py2,
			longint qx, longint qy, longint qx2, longint qy2,
			output longint ox, output longint oy);
		longint dax, day, dbx, dby, wx, wy, den, tn, un;
		dax = px2 - px;
		day = py2 - py;
		dbx = qx2 - qx;
		dby = qy2 - qy;
		wx  = qx - px;
		wy  = qy - py;
		den = dax * dby - day * dbx;
		tn  = wx * dby - wy * dbx;
		un  = wx * day - wy * dax;
		ox = 0;
		oy = 0;
		if (den == 0)
			return 0;
		if (den < 0) begin
			den = -den;
			tn  = -tn;
			un  = -un;
		end
		if (tn < 0 || tn > den || un < 0 || un > den)
			return 0;
		ox = (px * den + dax * tn) / den;
		oy = (py * den + day * tn) / den;
		return 1;
	endfunction

	// Note an accepted pair: a[] and b[] hold x0 y0 x1 y1 x2 y2.
	function void note_pair(logic signed [15:0] a[6], logic signed [15:0] b[6]);
		crossing_t c;
		longint ox, oy;
		int ia, ib;
		c = '{hit: 0, cx: 0, cy: 0, ea: 0, eb: 0};
		for (int eb = 0; eb < 3 && !c.hit; eb++) begin
			for (int ea = 0; ea < 3 && !c.hit; ea++) begin
				ia = (ea + 1) % 3;
				ib = (eb + 1) % 3;
				if (seg_hit(a[2*ea], a[2*ea+1], a[2*ia], a[2*ia+1],
						b[2*eb], b[2*eb+1], b[2*ib], b[2*ib+1], ox, oy)) begin
					c.hit = 1;
					c.cx  = ox[15:0];
					c.cy  = oy[15:0];
					c.ea  = ea[1:0];
					c.eb  = eb[1:0];
				end
			end
		end
		pending.push_back(c);
	endfunction

	function void check_result(logic hit, logic [15:0] cx, logic [15:0] cy,
			logic [1:0] ea, logic [1:0] eb);
		crossing_t e;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("ERROR: unexpected result hit=%0b x=%h y=%h", hit, cx, cy);
			return;
		end
		e = pending.pop_front();
		if (hit !== e.hit || cx !== e.cx || cy !== e.cy || ea !== e.ea || eb !== e.eb) begin
			errors++;
			if (errors <= 10)
				$display("ERROR: exp hit=%0b x=%h y=%h ea=%0d eb=%0d, got hit=%0b x=%h y=%h ea=%0d eb=%0d",
					e.hit, e.cx, e.cy, e.ea, e.eb, hit, cx, cy, ea, eb);
		end
	endfunction
endclass

// ===== tb/sv/tb_triangle_edge_intersection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_edge_intersection
// Streams triangle pairs through the crossing block under random source gaps
// and sink stalls, predicts each result and checks it in order.
// ----------------------------------------------------------------------------
module tb_triangle_edge_intersection;
	import tei_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	bit   done = 0;
	bit   calm = 0;     // set during the stretch with no idling

	tei_in_if  pair();
	tei_out_if result();

	triangle_edge_intersection dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair.sink),
		.result (result.source)
	);

	tei_crossing_board board = new();

	always #5 clk = ~clk;

	// Put one pair on the channel and hold it until the transfer.
	task automatic send_pair(logic signed [15:0] a[6], logic signed [15:0] b[6]);
		// random source gap with valid low, skipped during the calm stretch
		while (!calm && $urandom_range(99) < 13) begin
			pair.valid <= 0;
			@(posedge clk);
		end
		pair.valid <= 1;
		pair.a_x0 <= a[0]; pair.a_y0 <= a[1];
		pair.a_x1 <= a[2]; pair.a_y1 <= a[3];
		pair.a_x2 <= a[4]; pair.a_y2 <= a[5];
		pair.b_x0 <= b[0]; pair.b_y0 <= b[1];
		pair.b_x1 <= b[2]; pair.b_y1 <= b[3];
		pair.b_x2 <= b[4]; pair.b_y2 <= b[5];
		@(posedge clk);
		while (!pair.ready)
			@(posedge clk);
		board.note_pair(a, b);
	endtask

	// Random coordinate: mostly small to get real crossings, sometimes full range.
	function automatic logic signed [15:0] rnd_coord(int span);
		if ($urandom_range(9) == 0)
			return 16'($urandom);
		return 16'($signed($urandom_range(2 * span)) - span);
	endfunction

	// Sink side: stall at random and check every transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready)
				board.check_result(result.hit, result.cross_x, result.cross_y,
					result.edge_a, result.edge_b);
			result.ready <= calm || ($urandom_range(99) >= 13);
		end else begin
			result.ready <= 0;
		end
	end

	initial begin
		logic signed [15:0] a[6], b[6];
		int span;
		pair.valid <= 0;
		{pair.a_x0, pair.a_y0, pair.a_x1, pair.a_y1, pair.a_x2, pair.a_y2} <= '0;
		{pair.b_x0, pair.b_y0, pair.b_x1, pair.b_y1, pair.b_x2, pair.b_y2} <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: plain crossing of two triangles
		a = '{0, 0, 160, 0, 0, 160};       b = '{40, -40, 40, 200, -80, 40};
		send_pair(a, b);
		// far apart, no crossing
		a = '{0, 0, 16, 0, 0, 16};         b = '{800, 800, 816, 800, 800, 816};
		send_pair(a, b);
		// vertical edges
		a = '{0, 0, 0, 320, 160, 0};       b = '{-80, 160, 80, 160, 80, 400};
		send_pair(a, b);
		// touching at an endpoint
		a = '{0, 0, 100, 0, 0, 100};       b = '{100, 0, 200, 50, 200, -50};
		send_pair(a, b);
		// identical triangles: collinear pairs skipped, shared vertices hit
		a = '{0, 0, 64, 0, 0, 64};         b = a;
		send_pair(a, b);
		// collinear overlapping edges, with other edges touching them at endpoints
		a = '{0, 0, 100, 0, 50, 500};      b = '{50, 0, 150, 0, 100, -500};
		send_pair(a, b);
		// degenerate triangles: all vertices equal
		a = '{7, 7, 7, 7, 7, 7};           b = '{7, 7, 7, 7, 7, 7};
		send_pair(a, b);
		// extremes of the coordinate range
		a = '{-32768, -32768, 32767, 32767, -32768, 32767};
		b = '{32767, -32768, -32768, 32767, 32767, 32767};
		send_pair(a, b);
		a = '{-32768, 0, 32767, 0, 0, -32768}; b = '{0, -32768, 0, 32767, -1, -1};
		send_pair(a, b);
		a = '{32767, 32767, 32767, 32767, -1, -1}; b = '{-32768, -32768, 0, 0, -32768, 0};
		send_pair(a, b);
		// negative coordinates and truncation toward zero
		a = '{-3, -7, 11, 5, -9, 13};      b = '{-11, 2, 6, -8, 4, 9};
		send_pair(a, b);

		// Random part, with a long calm stretch in the middle
		for (int n = 0; n < 2000; n++) begin
			calm = (n >= 800 && n < 1100);
			span = ($urandom_range(3) == 0) ? 32767 : 200;
			foreach (a[i]) a[i] = rnd_coord(span);
			foreach (b[i]) b[i] = rnd_coord(span);
			// occasional shared or repeated vertices
			if ($urandom_range(9) == 0) begin
				b[0] = a[2];
				b[1] = a[3];
			end
			if ($urandom_range(19) == 0) begin
				a[2] = a[0];
				a[3] = a[1];
			end
			send_pair(a, b);
		end
		calm = 0;
		pair.valid <= 0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		done = 1;
		$finish;
	end

	// Hard limit on run time.
	initial begin
		#2000000;
		if (!done) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end
endmodule

// ===== filelist.f =====
rtl/tei_pkg.sv
rtl/tei_in_if.sv
rtl/tei_out_if.sv
rtl/tei_front.sv
rtl/tei_queue.sv
rtl/tei_div.sv
rtl/tei_back.sv
rtl/triangle_edge_intersection.sv
tb/sv/tei_tb_scoreboard.sv
tb/sv/tb_triangle_edge_intersection.sv
